/* hdl/bdlp_pkg.sv */
// Shared types, event codes and register defaults for the button debounce block.
`default_nettype none

package bdlp_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd25;
  localparam logic [CFG_W-1:0] GUARD_RST      = 16'd60;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd900;

  localparam logic [BTN_W-1:0] MASK_LEFT   = 3'b001;
  localparam logic [BTN_W-1:0] MASK_RIGHT  = 3'b010;
  localparam logic [BTN_W-1:0] MASK_CENTER = 3'b100;

  typedef enum logic [CIDX_W-1:0] {
    REG_DEBOUNCE   = 8'd0,
    REG_GUARD      = 8'd1,
    REG_LONG_PRESS = 8'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CENTER = 3'd1,
    EV_LEFT   = 3'd2,
    EV_RIGHT  = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] repeat_guard_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/button_debounce_long_press.sv */
// Top level of the button debounce and long-press detector.
// Throughput: one item per cycle unless out_stall holds back a full result;
// the state update is a single pass of compares.
// The input register and the result register each hold one item, so a new
// sample can be taken while a finished result still waits downstream.
// Reset (rst, synchronous) restores register defaults and clears control state.
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Sample channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BTN_W-1:0]  raw_buttons,
  input  wire logic [TIME_W-1:0] now_ms,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             event_res,
  // Configuration write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cfg_t              cfg;
  logic              hold_valid;
  logic [BTN_W-1:0]  hold_raw;
  logic [TIME_W-1:0] hold_now;
  logic              advance;
  logic              in_take;
  event_t            ev;

  // Registers always writable; user must keep block idle on change; not enforced.
  assign cfg_ready = 1'b1;

  bdlp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on when the result slot is empty or being emptied.
  // The state machine in bdlp_eval commits at the same edge, so the item
  // right behind it sees the updated state.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_raw <= raw_buttons;
      hold_now <= now_ms;
    end
  end

  bdlp_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .raw  (hold_raw),
    .now  (hold_now),
    .cfg  (cfg),
    .ev   (ev)
  );

  // Result register: every sample yields exactly one result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res <= ev;
    end
  end

`ifndef SYNTHESIS
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result slot empty after an item advanced");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && out_valid && out_stall))
    else $error("sample channel stalled without a blocked result");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == EV_NONE || event_res == EV_CENTER ||
                   event_res == EV_LEFT || event_res == EV_RIGHT ||
                   event_res == EV_LONG))
    else $error("result item carries an undefined event code");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !hold_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

/* hdl/bdlp_cfg.sv */
// Configuration register file for the button debounce block.
`default_nettype none

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [CIDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RST;
      cfg.repeat_guard_ms <= GUARD_RST;
      cfg.long_press_ms   <= LONG_PRESS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE:   cfg.debounce_ms     <= wr_data;
        REG_GUARD:      cfg.repeat_guard_ms <= wr_data;
        REG_LONG_PRESS: cfg.long_press_ms   <= wr_data;
        default: begin
          // Writes outside the register list are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/bdlp_eval.sv */
// Debounce and press tracking state with the single-pass event decision.
`default_nettype none

module bdlp_eval
  import bdlp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BTN_W-1:0]  raw,
  input  wire logic [TIME_W-1:0] now,
  input  wire cfg_t              cfg,
  output event_t                 ev
);

  logic [BTN_W-1:0]  last_raw, last_raw_next;
  logic [TIME_W-1:0] change_time, change_time_next;
  logic [BTN_W-1:0]  stable, stable_next;
  logic              press, press_next;
  logic              long_sent, long_sent_next;
  logic [BTN_W-1:0]  latched, latched_next;
  logic [TIME_W-1:0] start_time, start_time_next;
  logic [TIME_W-1:0] event_time, event_time_next;

  logic [TIME_W-1:0] since_change, since_start, since_event;
  logic              settling, guard_block, long_due;

  assign since_change = now - change_time;
  assign since_start  = now - start_time;
  assign since_event  = now - event_time;

  assign settling    = since_change < {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
  assign guard_block = since_event < {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_guard_ms};
  assign long_due    = since_start >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};

  always_comb begin
    last_raw_next    = last_raw;
    change_time_next = change_time;
    stable_next      = stable;
    press_next       = press;
    long_sent_next   = long_sent;
    latched_next     = latched;
    start_time_next  = start_time;
    event_time_next  = event_time;
    ev               = EV_NONE;

    if (raw != last_raw) begin
      last_raw_next    = raw;
      change_time_next = now;
    end else if (settling) begin
      ev = EV_NONE;
    end else if (raw != stable) begin
      stable_next = raw;
      if (raw != '0 && !press) begin
        press_next      = 1'b1;
        long_sent_next  = 1'b0;
        latched_next    = raw;
        start_time_next = now;
      end else if (raw == '0 && press) begin
        press_next = 1'b0;
        if (!guard_block && !long_sent) begin
          event_time_next = now;
          if ((latched & MASK_CENTER) != '0) begin
            ev = EV_CENTER;
          end else if (latched == MASK_LEFT) begin
            ev = EV_LEFT;
          end else if (latched == MASK_RIGHT) begin
            ev = EV_RIGHT;
          end
        end
      end
    end else if (press && !long_sent && (stable & MASK_CENTER) != '0 && long_due) begin
      long_sent_next  = 1'b1;
      event_time_next = now;
      ev              = EV_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw    <= '0;
      change_time <= '0;
      stable      <= '0;
      press       <= 1'b0;
      long_sent   <= 1'b0;
      latched     <= '0;
      start_time  <= '0;
      event_time  <= '0;
    end else if (step) begin
      last_raw    <= last_raw_next;
      change_time <= change_time_next;
      stable      <= stable_next;
      press       <= press_next;
      long_sent   <= long_sent_next;
      latched     <= latched_next;
      start_time  <= start_time_next;
      event_time  <= event_time_next;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/button_debounce_long_press_tb.sv */
// Self-checking testbench for the button debounce and long-press detector.
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  // An empty sample and two combined masks, spelled from the package masks.
  localparam logic [BTN_W-1:0] NO_BUTTONS = '0;
  localparam logic [BTN_W-1:0] LEFT_RIGHT = MASK_LEFT | MASK_RIGHT;
  localparam logic [BTN_W-1:0] ALL_BUTTONS = MASK_LEFT | MASK_RIGHT | MASK_CENTER;

  // Register indexes past the end of the register file; writes there are dropped.
  localparam logic [CIDX_W-1:0] IDX_PAST_END = CIDX_W'(REG_LONG_PRESS) + 1'b1;
  localparam logic [CIDX_W-1:0] IDX_TOP = '1;

  localparam int unsigned SEGMENTS = 6;
  localparam int unsigned SEG_ITEMS = 96;
  localparam int unsigned HOLDOFF_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One row of the directed table. When has_want is set, the expected event is
  // typed into the row; otherwise the predictor supplies it.
  typedef struct {
    logic [BTN_W-1:0]  raw;
    logic [TIME_W-1:0] now;
    bit                has_want;
    event_t            want;
  } sample_row_t;

  // The directed part runs with the reset register values: 25 ms debounce,
  // 60 ms repeat guard and 900 ms long press.
  sample_row_t directed_rows [0:28] = '{
    // Right after reset nothing has settled yet.
    '{NO_BUTTONS,  32'd0,   1'b1, EV_NONE},
    // Center press, then a release sampled one short of the debounce time and at it.
    '{MASK_CENTER, 32'd100, 1'b0, EV_NONE},
    '{MASK_CENTER, 32'd125, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd130, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd154, 1'b1, EV_NONE},
    '{NO_BUTTONS,  32'd155, 1'b1, EV_CENTER},
    // Left press released well after the guard.
    '{MASK_LEFT,   32'd200, 1'b0, EV_NONE},
    '{MASK_LEFT,   32'd225, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd230, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd255, 1'b1, EV_LEFT},
    // Right press released inside the repeat guard: swallowed.
    '{MASK_RIGHT,  32'd256, 1'b0, EV_NONE},
    '{MASK_RIGHT,  32'd281, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd282, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd307, 1'b1, EV_NONE},
    // Right press released after the guard.
    '{MASK_RIGHT,  32'd400, 1'b0, EV_NONE},
    '{MASK_RIGHT,  32'd425, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd430, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd455, 1'b0, EV_NONE},
    // Left and right together, then all three while still pressed. The
    // latched mask stays left plus right, so the release reports nothing.
    '{LEFT_RIGHT,  32'd500, 1'b0, EV_NONE},
    '{LEFT_RIGHT,  32'd525, 1'b0, EV_NONE},
    '{ALL_BUTTONS, 32'd530, 1'b0, EV_NONE},
    '{ALL_BUTTONS, 32'd555, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd560, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'd585, 1'b0, EV_NONE},
    // Center press across the time wrap, held into a long press, and a
    // release that stays silent because the long press was already sent.
    '{MASK_CENTER, 32'hFFFF_FFFF, 1'b0, EV_NONE},
    '{MASK_CENTER, 32'h0000_0018, 1'b0, EV_NONE},
    '{MASK_CENTER, 32'h0000_039C, 1'b1, EV_LONG},
    '{NO_BUTTONS,  32'h0000_03A0, 1'b0, EV_NONE},
    '{NO_BUTTONS,  32'h0000_03B9, 1'b1, EV_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BTN_W-1:0]  raw_buttons = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        event_res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  button_debounce_long_press u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_buttons (raw_buttons),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 20 ns clock period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor copy of the configuration registers.
  logic [CFG_W-1:0] cfg_debounce;
  logic [CFG_W-1:0] cfg_guard;
  logic [CFG_W-1:0] cfg_long;

  // Predictor copy of the debounce and press tracking state.
  logic [BTN_W-1:0]  prev_raw;
  logic [TIME_W-1:0] settle_start;
  logic [BTN_W-1:0]  stable_mask;
  logic              in_press;
  logic              long_done;
  logic [BTN_W-1:0]  press_mask;
  logic [TIME_W-1:0] press_t0;
  logic [TIME_W-1:0] last_report_t;

  // Events still owed by the block, oldest first. Every accepted item owes
  // exactly one event, including the "no event" code.
  event_t expected_events [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Stimulus shaping, set by the main sequence and read by the drivers.
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned holdoff_asks = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;

  // Running millisecond time of the random part, and the largest step between
  // two held or released samples, scaled to the current register values.
  logic [TIME_W-1:0] clock_ms;
  logic [TIME_W-1:0] step_ms;
  int unsigned seg_count;

  function automatic void reset_predictor();
    cfg_debounce  = DEBOUNCE_RST;
    cfg_guard     = GUARD_RST;
    cfg_long      = LONG_PRESS_RST;
    prev_raw      = NO_BUTTONS;
    settle_start  = '0;
    stable_mask   = NO_BUTTONS;
    in_press      = 1'b0;
    long_done     = 1'b0;
    press_mask    = NO_BUTTONS;
    press_t0      = '0;
    last_report_t = '0;
  endfunction

  // Works out the event for one accepted sample and advances the predictor
  // state. All time differences wrap at 32 bits.
  function automatic event_t predict_event(input logic [BTN_W-1:0] raw,
                                           input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_report;
    logic [TIME_W-1:0] since_press;
    held         = now - settle_start;
    since_report = now - last_report_t;
    since_press  = now - press_t0;
    // Any raw change restarts the debounce window.
    if (raw != prev_raw) begin
      prev_raw     = raw;
      settle_start = now;
      return EV_NONE;
    end
    if (held < TIME_W'(cfg_debounce)) begin
      return EV_NONE;
    end
    if (raw != stable_mask) begin
      stable_mask = raw;
      // The first nonzero stable mask opens a press and latches its buttons.
      if (raw != NO_BUTTONS && !in_press) begin
        in_press   = 1'b1;
        long_done  = 1'b0;
        press_mask = raw;
        press_t0   = now;
        return EV_NONE;
      end
      // Release: silent inside the guard or after a long press; a combined
      // mask without center still moves the guard time but reports nothing.
      if (raw == NO_BUTTONS && in_press) begin
        in_press = 1'b0;
        if (since_report < TIME_W'(cfg_guard) || long_done) begin
          return EV_NONE;
        end
        last_report_t = now;
        if ((press_mask & MASK_CENTER) != NO_BUTTONS) begin
          return EV_CENTER;
        end
        if (press_mask == MASK_LEFT) begin
          return EV_LEFT;
        end
        if (press_mask == MASK_RIGHT) begin
          return EV_RIGHT;
        end
      end
      return EV_NONE;
    end
    // A held center reports the long press once per press.
    if (in_press && !long_done && (stable_mask & MASK_CENTER) != NO_BUTTONS &&
        since_press >= TIME_W'(cfg_long)) begin
      long_done     = 1'b1;
      last_report_t = now;
      return EV_LONG;
    end
    return EV_NONE;
  endfunction

  // Offers one sample, with random idle cycles ahead of it, and waits until
  // the block takes it. Payload and valid only change on falling edges.
  task automatic send_sample(input logic [BTN_W-1:0] raw, input logic [TIME_W-1:0] now,
                             input bit has_want, input event_t want);
    event_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    raw_buttons <= raw;
    now_ms      <= now;
    do @(posedge clk); while (in_stall);
    predicted = predict_event(raw, now);
    expected_events.push_back(has_want ? want : predicted);
  endtask

  // Lowers valid and waits until every owed event has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DEBOUNCE) begin
      cfg_debounce = value;
    end else if (idx == REG_GUARD) begin
      cfg_guard = value;
    end else if (idx == REG_LONG_PRESS) begin
      cfg_long = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Advances the running time and sends one random-part sample.
  task automatic emit(input logic [BTN_W-1:0] raw, input logic [TIME_W-1:0] dt);
    clock_ms = clock_ms + dt;
    send_sample(raw, clock_ms, 1'b0, EV_NONE);
    seg_count++;
  endtask

  // Center, left and right alone come up in three of four draws; otherwise any nonzero mask.
  function automatic logic [BTN_W-1:0] pick_mask();
    case ($urandom_range(3))
      0: return MASK_CENTER;
      1: return MASK_LEFT;
      2: return MASK_RIGHT;
      default: return BTN_W'($urandom_range(7, 1));
    endcase
  endfunction

  // A well-formed press: contact bounce, a hold long enough to settle most of
  // the time, sometimes a change of buttons mid-press, bounce, and a release.
  task automatic press_sequence();
    logic [BTN_W-1:0] mask;
    mask = pick_mask();
    repeat ($urandom_range(2)) emit(BTN_W'($urandom_range(7)), $urandom_range(3));
    repeat ($urandom_range(12, 1)) emit(mask, $urandom_range(step_ms));
    if ($urandom_range(4) == 0) begin
      mask = pick_mask();
      repeat ($urandom_range(6, 1)) emit(mask, $urandom_range(step_ms));
    end
    repeat ($urandom_range(2)) emit(BTN_W'($urandom_range(7)), $urandom_range(3));
    repeat ($urandom_range(8, 1)) emit(NO_BUTTONS, $urandom_range(step_ms));
  endtask

  // Unstructured samples; now and then the time jumps anywhere in its range.
  task automatic noise_burst();
    if ($urandom_range(3) == 0) begin
      clock_ms = $urandom();
    end
    repeat ($urandom_range(6, 1)) emit(BTN_W'($urandom_range(7)), $urandom_range(step_ms));
  endtask

  // Receiver: stalls at random, or for a long stretch when one is asked for.
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_asks) begin
      holdoff_seen = holdoff_asks;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Result checker: every accepted result is matched against the oldest
  // expectation. Only the first ten failures are printed.
  always @(posedge clk) begin : check_results
    event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: event_res=%0d with nothing owed", event_res);
        end
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("event mismatch: expected %0d, got %0d", want, event_res);
          end
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : main_sequence
    logic [TIME_W-1:0] base_ms;
    bit paused;
    reset_predictor();
    paused = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the first idling pattern.
    snd_idle_pct = 26;
    rcv_idle_pct = 85;
    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].raw, directed_rows[i].now,
                  directed_rows[i].has_want, directed_rows[i].want);
    end

    // Random part in segments. Each segment starts from an idle block with
    // fresh register values: first the low extremes, then the high extremes,
    // then random small values that keep events frequent.
    clock_ms = $urandom();
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      if (seg < 2) begin
        snd_idle_pct = 26;
        rcv_idle_pct = 85;
      end else if (seg < 4) begin
        snd_idle_pct = 85;
        rcv_idle_pct = 26;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (seg == 0) begin
        write_register(REG_DEBOUNCE, '0);
        write_register(REG_GUARD, '0);
        write_register(REG_LONG_PRESS, '0);
      end else if (seg == 1) begin
        write_register(REG_DEBOUNCE, '1);
        write_register(REG_GUARD, '1);
        write_register(REG_LONG_PRESS, '1);
      end else begin
        write_register(REG_DEBOUNCE, CFG_W'($urandom_range(30)));
        write_register(REG_GUARD, CFG_W'($urandom_range(120)));
        write_register(REG_LONG_PRESS, CFG_W'($urandom_range(400)));
      end
      // Writes past the register file must leave every setting alone.
      if (seg == 2) begin
        write_register(IDX_PAST_END, CFG_W'($urandom()));
        write_register(IDX_TOP, CFG_W'($urandom()));
      end

      // Step size follows the larger of the debounce time and a share of the
      // long-press time, so holds settle often and sometimes go long.
      base_ms = (cfg_long / 6 > cfg_debounce) ? TIME_W'(cfg_long / 6) : TIME_W'(cfg_debounce);
      step_ms = base_ms / 2 + 2;

      // With no idling on the sender, a long receiver stall fills the block
      // and pushes the stall back onto the input channel.
      if (seg == 4) begin
        @(posedge clk);
        holdoff_asks++;
      end

      seg_count = 0;
      while (seg_count < SEG_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          press_sequence();
        end else begin
          noise_burst();
        end
        // Once, the sender waits for the block to empty completely.
        if (seg == 3 && !paused && seg_count >= SEG_ITEMS / 2) begin
          paused = 1'b1;
          drain_results();
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
